// File: rtl/core/mxs_pkg.sv
// ----------------------------------------------------------------------------
// MIPS exception PC sequencer package
// Shared types, register indexes and vector constants for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package mxs_pkg;

  // Exception vector layout.
  localparam logic [63:0] VecNormal     = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] VecBoot       = 64'hFFFF_FFFF_BFC0_0200;
  localparam logic [63:0] VecOffGeneral = 64'h0000_0000_0000_0180;
  localparam logic [63:0] VecOffTlb     = 64'h0000_0000_0000_0000;
  localparam logic [63:0] StartReset    = 64'hFFFF_FFFF_BFC0_0000;
  localparam logic [63:0] PcStep        = 64'd4;
  localparam logic [63:0] PcSkip        = 64'd8;

  localparam logic [4:0] RandomTop    = 5'd31;
  localparam logic [4:0] ExcInterrupt = 5'd0;
  localparam logic [4:0] ExcTlbLoad   = 5'd2;
  localparam logic [4:0] ExcTlbStore  = 5'd3;

  // Branch kinds carried by an input transaction.
  localparam logic [1:0] BrTaken = 2'd1;
  localparam logic [1:0] BrSkip  = 2'd2;

  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IRQ_MASK      = 3'd0,
    REG_IRQ_ENABLE    = 3'd1,
    REG_ERROR_LEVEL   = 3'd2,
    REG_BOOT_VECTORS  = 3'd3,
    REG_WIRED_LIMIT   = 3'd4,
    REG_START_ADDRESS = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic        op;
    logic [4:0]  exc_code;
    logic [1:0]  cop_unit;
    logic [1:0]  branch_kind;
    logic [63:0] branch_target;
    logic [7:0]  interrupt_lines;
  } in_item_t;

  typedef struct packed {
    logic [63:0] next_pc;
    logic [63:0] exc_pc;
    logic        exc_level;
    logic [4:0]  cause_code;
    logic [1:0]  cause_cop;
    logic        cause_delay;
    logic [7:0]  pending_ip;
    logic [4:0]  random_value;
    logic        trapped;
  } out_item_t;

  typedef struct packed {
    logic [7:0] irq_mask;
    logic       irq_enable;
    logic       error_level;
    logic       boot_vectors;
    logic [4:0] wired_limit;
  } cfg_t;

  // Architectural state. The branch sequencer only ever rests in "step" or
  // "delay slot pending", so one bit holds it between instructions.
  typedef struct packed {
    logic [63:0] pc;
    logic        in_delay;
    logic [63:0] branch_dest;
    logic [63:0] ret_addr;
    logic        in_exception;
    logic [4:0]  code_field;
    logic [1:0]  cop_field;
    logic        delay_field;
    logic [7:0]  ip_field;
    logic [4:0]  random_index;
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/mxs_step.sv
// ----------------------------------------------------------------------------
// MIPS exception PC sequencer step logic
// Computes the next architectural state and the result for one instruction.
// ----------------------------------------------------------------------------
`default_nettype none

module mxs_step (
  input  mxs_pkg::state_t    state,
  input  mxs_pkg::cfg_t      cfg,
  input  mxs_pkg::in_item_t  item,
  output mxs_pkg::state_t    state_next,
  output mxs_pkg::out_item_t result
);
  import mxs_pkg::*;

  logic [7:0]  active;
  logic        irq;
  logic        take;
  logic [4:0]  code_eff;
  logic [1:0]  cop_eff;
  logic [63:0] vec_base;
  logic [63:0] vec_off;
  logic [4:0]  rand_dec;

  assign active   = item.interrupt_lines & cfg.irq_mask;
  assign irq      = (|active) && cfg.irq_enable && !state.in_exception && !cfg.error_level;
  assign take     = irq || item.op;
  assign code_eff = irq ? ExcInterrupt : item.exc_code;
  assign cop_eff  = irq ? active[1:0] : item.cop_unit;
  assign vec_base = cfg.boot_vectors ? VecBoot : VecNormal;
  assign vec_off  = (code_eff == ExcTlbLoad || code_eff == ExcTlbStore) ? VecOffTlb
                                                                        : VecOffGeneral;
  assign rand_dec = state.random_index - 5'd1;

  always_comb begin
    state_next          = state;
    state_next.ip_field = irq ? active : item.interrupt_lines;

    if (take) begin
      // Only the first exception captures the return address and delay bit.
      if (!state.in_exception) begin
        state_next.ret_addr     = state.in_delay ? state.pc - PcStep : state.pc;
        state_next.delay_field  = state.in_delay;
        state_next.in_exception = 1'b1;
      end
      state_next.code_field = code_eff;
      state_next.cop_field  = cop_eff;
      state_next.pc         = vec_base + vec_off;
      state_next.in_delay   = 1'b0;
    end else begin
      case (item.branch_kind)
        BrTaken: begin
          state_next.branch_dest = item.branch_target;
          state_next.pc          = state.pc + PcStep;
          state_next.in_delay    = 1'b1;
        end
        BrSkip: begin
          state_next.pc       = state.pc + PcSkip;
          state_next.in_delay = 1'b0;
        end
        default: begin
          state_next.pc       = state.in_delay ? state.branch_dest : state.pc + PcStep;
          state_next.in_delay = 1'b0;
        end
      endcase
    end

    // The random index counts for every instruction that is not interrupted.
    if (!irq) begin
      state_next.random_index = (rand_dec < cfg.wired_limit) ? RandomTop : rand_dec;
    end
  end

  always_comb begin
    result.next_pc      = state_next.pc;
    result.exc_pc       = state_next.ret_addr;
    result.exc_level    = state_next.in_exception;
    result.cause_code   = state_next.code_field;
    result.cause_cop    = state_next.cop_field;
    result.cause_delay  = state_next.delay_field;
    result.pending_ip   = state_next.ip_field;
    result.random_value = state_next.random_index;
    result.trapped      = take;
  end

endmodule

`default_nettype wire

// File: rtl/core/mips_exception_pc_sequencer.sv
// A transaction passes from the input register through the step logic into
// the result register. Throughput: one transaction per cycle unless out_ready
// stalls the output; the combinational step logic closes the state loop.
// Reset (rst, synchronous, active high) loads the PC with the boot start
// address, clears the exception fields, sets the random index to 31 and
// restores every configuration register to its reset value.
// ----------------------------------------------------------------------------
// MIPS exception PC sequencer
// Tracks the PC, branch delay slot, EPC, cause fields and random index for one
// retired instruction per transaction, taking interrupts and exceptions.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_exception_pc_sequencer (
  input  wire                             clk,
  input  wire                             rst,
  // Configuration write port.
  input  wire                             cfg_wen,
  input  wire  [mxs_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire  [63:0]                     cfg_wdata,
  // Retired instruction transactions.
  input  wire                             in_valid,
  output logic                            in_ready,
  input  mxs_pkg::in_item_t               in_data,
  // Results.
  output logic                            out_valid,
  input  wire                             out_ready,
  output mxs_pkg::out_item_t              out_data
);
  import mxs_pkg::*;

  // Configuration registers.
  cfg_t cfg;

  // Input register stage.
  logic     s1_valid;
  in_item_t s1_item;

  // Architectural state and step logic outputs.
  state_t    state;
  state_t    state_next;
  out_item_t step_result;

  logic advance;

  // The input stage moves forward whenever the result register is empty or
  // its transaction is taken in this cycle, so a full pipeline still accepts
  // a new transaction every cycle in which its result is taken.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  // Configuration writes. The start address register only matters at reset,
  // where it always holds its reset value, so a write to it changes nothing
  // that the block can observe and it needs no storage.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.irq_mask     <= '0;
      cfg.irq_enable   <= 1'b0;
      cfg.error_level  <= 1'b0;
      cfg.boot_vectors <= 1'b1;
      cfg.wired_limit  <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_IRQ_MASK:      cfg.irq_mask     <= cfg_wdata[7:0];
        REG_IRQ_ENABLE:    cfg.irq_enable   <= cfg_wdata[0];
        REG_ERROR_LEVEL:   cfg.error_level  <= cfg_wdata[0];
        REG_BOOT_VECTORS:  cfg.boot_vectors <= cfg_wdata[0];
        REG_WIRED_LIMIT:   cfg.wired_limit  <= cfg_wdata[4:0];
        REG_START_ADDRESS: ;
        default:           ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  mxs_step u_step (
    .state      (state),
    .cfg        (cfg),
    .item       (s1_item),
    .state_next (state_next),
    .result     (step_result)
  );

  // The state commits in the same edge that the result is registered, so the
  // next transaction in the input stage always sees the updated state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.pc           <= StartReset;
      state.in_delay     <= 1'b0;
      state.branch_dest  <= '0;
      state.ret_addr     <= '0;
      state.in_exception <= 1'b0;
      state.code_field   <= '0;
      state.cop_field    <= '0;
      state.delay_field  <= 1'b0;
      state.ip_field     <= '0;
      state.random_index <= RandomTop;
    end else if (s1_valid && advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      out_data <= step_result;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mxs_checker.sv
// ----------------------------------------------------------------------------
// MIPS exception PC sequencer checker
// Port-level assertions on the sequencer, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module mxs_checker (
  input wire                         clk,
  input wire                         rst,
  input wire                         in_valid,
  input wire                         in_ready,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire mxs_pkg::out_item_t     out_data
);
  import mxs_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The input only stalls behind a result that is held off.
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // A taken trap always leaves the exception level set.
  a_trap_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.trapped |-> out_data.exc_level)
    else $error("trap taken without exception level");

  // A trap lands on the TLB refill vector or on the general vector.
  a_trap_vector: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.trapped |->
      (((out_data.cause_code == ExcTlbLoad) || (out_data.cause_code == ExcTlbStore))
         ? (out_data.next_pc[8:0] == 9'h000)
         : (out_data.next_pc[8:0] == 9'h180)))
    else $error("trap vector offset wrong");

endmodule

bind mips_exception_pc_sequencer mxs_checker u_mxs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// Exception PC sequencer testbench
// Drives retired-instruction transactions through the sequencer under random
// idling on both sides and checks every result against a built-in predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import mxs_pkg::*;

  localparam int ClockLimit = 200000;
  localparam int HoldCycles = 300;

  // Branch sequencer phases of the predictor. They are local to the testbench.
  typedef enum logic [2:0] {
    SEQ_STEP,
    SEQ_TAKE,
    SEQ_DELAY,
    SEQ_EXC,
    SEQ_SKIP
  } seq_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every input of the block starts at a known value.
  logic        cfg_wen = 1'b0;
  cfg_reg_t    cfg_index = REG_IRQ_MASK;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  mips_exception_pc_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Instructions waiting to be offered, and register views still due back.
  in_item_t  instr_q[$];
  out_item_t regs_due[$];

  int  mismatches = 0;
  int  cycles = 0;
  bit  calm = 1'b0;       // When set, neither side idles.
  int  hold_reqs = 0;     // Bumped by the stimulus to ask for a long output stall.

  // Shadow copy of the configuration registers. The start address never
  // reaches the PC outside reset, so it has no shadow.
  logic [7:0]  sh_mask;
  logic        sh_enable;
  logic        sh_err;
  logic        sh_boot;
  logic [4:0]  sh_wired;

  // Shadow copy of the architectural state.
  logic [63:0] pc;
  seq_phase_t  phase;
  logic [63:0] br_dest;
  logic [63:0] epc;
  logic        in_exc;
  logic [4:0]  code_q;
  logic [1:0]  cop_q;
  logic        delay_bit;
  logic [7:0]  ip_q;
  logic [4:0]  rnd;

  // Enter an exception or interrupt. The return address and the delay bit are
  // only captured when the exception level is clear; a nested trap just
  // rewrites the cause code and coprocessor fields and re-vectors the PC.
  function automatic void enter_trap(logic [4:0] code, logic [1:0] cop);
    logic in_slot;
    in_slot = (phase == SEQ_DELAY);
    if (!in_exc) begin
      epc       = in_slot ? pc - PcStep : pc;
      delay_bit = in_slot;
      in_exc    = 1'b1;
    end
    code_q = code;
    cop_q  = cop;
    pc = (sh_boot ? VecBoot : VecNormal)
       + ((code == ExcTlbLoad || code == ExcTlbStore) ? VecOffTlb : VecOffGeneral);
    phase = SEQ_EXC;
  endfunction

  // Advance the shadow state by one retired instruction and return the
  // register view that the block should report for it.
  function automatic out_item_t retire_instr(in_item_t it);
    logic [7:0] active;
    logic       took;
    out_item_t  view;
    active = it.interrupt_lines & sh_mask;
    took   = 1'b0;
    ip_q   = it.interrupt_lines;
    if (active != 8'd0 && sh_enable && !in_exc && !sh_err) begin
      // An interrupt keeps only the unmasked lines, sends the branch sequencer
      // back to step and leaves the random index alone.
      ip_q = active;
      enter_trap(ExcInterrupt, active[1:0]);
      phase = SEQ_STEP;
      took  = 1'b1;
    end else begin
      if (it.op) begin
        enter_trap(it.exc_code, it.cop_unit);
        took = 1'b1;
      end else if (it.branch_kind == BrTaken) begin
        phase   = SEQ_TAKE;
        br_dest = it.branch_target;
      end else if (it.branch_kind == BrSkip) begin
        phase = SEQ_SKIP;
      end
      case (phase)
        SEQ_TAKE: begin
          pc    = pc + PcStep;
          phase = SEQ_DELAY;
        end
        SEQ_DELAY: begin
          pc    = br_dest;
          phase = SEQ_STEP;
        end
        SEQ_EXC: begin
          phase = SEQ_STEP;
        end
        SEQ_SKIP: begin
          pc    = pc + PcSkip;
          phase = SEQ_STEP;
        end
        default: begin
          pc    = pc + PcStep;
          phase = SEQ_STEP;
        end
      endcase
      rnd = rnd - 5'd1;
      if (rnd < sh_wired) rnd = RandomTop;
    end
    view.next_pc      = pc;
    view.exc_pc       = epc;
    view.exc_level    = in_exc;
    view.cause_code   = code_q;
    view.cause_cop    = cop_q;
    view.cause_delay  = delay_bit;
    view.pending_ip   = ip_q;
    view.random_value = rnd;
    view.trapped      = took;
    return view;
  endfunction

  // Driver: predicts each accepted transaction and offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) regs_due.push_back(retire_instr(in_data));
      if (!in_valid || in_ready) begin
        if (instr_q.size() > 0 && (calm || $urandom_range(99) >= 28)) begin
          in_valid <= 1'b1;
          in_data  <= instr_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver side: random idling, plus a long hold-off whenever asked for.
  int holds_taken = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_reqs != holds_taken) begin
      holds_taken <= hold_reqs;
      stall_left  <= HoldCycles;
      out_ready   <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 28);
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %h, got %h", name, want, got);
    end
  endtask

  // Monitor: every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (regs_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no transaction pending: %h", out_data);
      end else begin
        want = regs_due.pop_front();
        check_field("next_pc", want.next_pc, out_data.next_pc);
        check_field("exc_pc", want.exc_pc, out_data.exc_pc);
        check_field("exc_level", 64'(want.exc_level), 64'(out_data.exc_level));
        check_field("cause_code", 64'(want.cause_code), 64'(out_data.cause_code));
        check_field("cause_cop", 64'(want.cause_cop), 64'(out_data.cause_cop));
        check_field("cause_delay", 64'(want.cause_delay), 64'(out_data.cause_delay));
        check_field("pending_ip", 64'(want.pending_ip), 64'(out_data.pending_ip));
        check_field("random_value", 64'(want.random_value), 64'(out_data.random_value));
        check_field("trapped", 64'(want.trapped), 64'(out_data.trapped));
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == ClockLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // A register is written only while nothing is in flight, so the shadow copy
  // can be updated at the same time as the block's copy.
  task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_IRQ_MASK:      sh_mask   = value[7:0];
      REG_IRQ_ENABLE:    sh_enable = value[0];
      REG_ERROR_LEVEL:   sh_err    = value[0];
      REG_BOOT_VECTORS:  sh_boot   = value[0];
      REG_WIRED_LIMIT:   sh_wired  = value[4:0];
      REG_START_ADDRESS: ;
      default: ;
    endcase
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Wait until every queued instruction has been taken and every result has
  // come back, then let the pipeline settle.
  task automatic drain();
    while (instr_q.size() != 0 || in_valid || regs_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic in_item_t mk(logic op, logic [4:0] code, logic [1:0] cop,
                                  logic [1:0] kind, logic [63:0] target,
                                  logic [7:0] lines);
    in_item_t it;
    it.op              = op;
    it.exc_code        = code;
    it.cop_unit        = cop;
    it.branch_kind     = kind;
    it.branch_target   = target;
    it.interrupt_lines = lines;
    return it;
  endfunction

  // Random instruction. Without faults the stream is only normal retirement,
  // which keeps the exception level clear and the branch sequencer busy.
  function automatic in_item_t rand_instr(bit faults);
    in_item_t it;
    it.op = faults && ($urandom_range(99) < 25);
    if ($urandom_range(9) < 3) it.exc_code = $urandom_range(1) ? ExcTlbLoad : ExcTlbStore;
    else it.exc_code = 5'($urandom_range(31));
    it.cop_unit      = 2'($urandom_range(3));
    it.branch_kind   = ($urandom_range(9) < 4) ? BrTaken : 2'($urandom_range(3));
    it.branch_target = {$urandom, $urandom};
    it.interrupt_lines = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255));
    return it;
  endfunction

  initial begin
    sh_mask   = 8'd0;
    sh_enable = 1'b0;
    sh_err    = 1'b0;
    sh_boot   = 1'b1;
    sh_wired  = 5'd0;
    pc        = StartReset;
    phase     = SEQ_STEP;
    br_dest   = '0;
    epc       = '0;
    in_exc    = 1'b0;
    code_q    = '0;
    cop_q     = '0;
    delay_bit = 1'b0;
    ip_q      = '0;
    rnd       = RandomTop;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: branch sequencer corners, some lines raised but masked.
    instr_q.push_back(mk(1'b0, 5'd0, 2'd0, 2'd0, 64'd0, 8'd0));
    instr_q.push_back(mk(1'b0, 5'd31, 2'd3, BrTaken, '1, 8'hFF));
    instr_q.push_back(mk(1'b0, 5'd0, 2'd0, 2'd0, 64'd0, 8'd0));
    // A new branch inside a delay slot replaces the pending one.
    instr_q.push_back(mk(1'b0, 5'd0, 2'd0, BrTaken, 64'd0, 8'd0));
    instr_q.push_back(mk(1'b0, 5'd0, 2'd0, BrTaken, 64'h0000_0000_0040_1000, 8'd0));
    instr_q.push_back(mk(1'b0, 5'd0, 2'd0, 2'd0, 64'd0, 8'h01));
    instr_q.push_back(mk(1'b0, 5'd0, 2'd0, BrSkip, '1, 8'h80));
    // Branch kind 3 behaves like no branch.
    instr_q.push_back(mk(1'b0, 5'd0, 2'd0, 2'd3, '1, 8'd0));
    // A likely-not-taken branch in a delay slot skips past the slot.
    instr_q.push_back(mk(1'b0, 5'd0, 2'd0, BrTaken, 64'h0000_0000_0000_2000, 8'd0));
    instr_q.push_back(mk(1'b0, 5'd0, 2'd0, BrSkip, 64'd0, 8'd0));
    drain();

    // Wired limit at its top pins the random index; interrupts still disabled.
    write_reg(REG_WIRED_LIMIT, 64'd31);
    write_reg(REG_IRQ_MASK, 64'hFF);
    write_reg(REG_IRQ_ENABLE, 64'd0);
    write_reg(REG_START_ADDRESS, 64'd0);
    @(negedge clk);
    repeat (250) instr_q.push_back(rand_instr(1'b0));
    drain();

    // The error level blocks interrupts even though they are enabled. The
    // output side holds off for a long stretch so the block backs up.
    write_reg(REG_WIRED_LIMIT, 64'd0);
    write_reg(REG_ERROR_LEVEL, 64'd1);
    write_reg(REG_IRQ_ENABLE, 64'd1);
    @(negedge clk);
    instr_q.push_back(mk(1'b0, 5'd0, 2'd0, 2'd0, 64'd0, 8'hFF));
    repeat (250) instr_q.push_back(rand_instr(1'b0));
    hold_reqs++;
    drain();

    // First trap: an interrupt taken in a delay slot, on the normal vectors.
    write_reg(REG_ERROR_LEVEL, 64'd0);
    write_reg(REG_BOOT_VECTORS, 64'd0);
    write_reg(REG_IRQ_MASK, 64'hA6);
    write_reg(REG_WIRED_LIMIT, 64'd9);
    @(negedge clk);
    instr_q.push_back(mk(1'b0, 5'd0, 2'd0, 2'd0, 64'd0, 8'h01));
    instr_q.push_back(mk(1'b0, 5'd0, 2'd0, BrTaken, 64'h0000_0000_0000_8000, 8'h00));
    instr_q.push_back(mk(1'b0, 5'd0, 2'd0, 2'd0, 64'd0, 8'hFF));
    // With the exception level now set, further traps only rewrite the cause
    // fields and the PC; a faulting instruction's branch fields are ignored.
    instr_q.push_back(mk(1'b1, ExcTlbLoad, 2'd1, BrTaken, '1, 8'hFF));
    instr_q.push_back(mk(1'b1, ExcTlbStore, 2'd2, BrSkip, 64'd0, 8'd0));
    instr_q.push_back(mk(1'b1, ExcInterrupt, 2'd3, 2'd0, 64'd0, 8'd0));
    instr_q.push_back(mk(1'b0, 5'd0, 2'd0, BrTaken, 64'h0000_0000_0000_4000, 8'd0));
    instr_q.push_back(mk(1'b1, 5'd31, 2'd0, 2'd0, 64'd0, 8'd0));
    drain();

    write_reg(REG_BOOT_VECTORS, 64'd1);
    write_reg(REG_WIRED_LIMIT, 64'd20);
    write_reg(REG_START_ADDRESS, '1);
    write_reg(REG_IRQ_MASK, 64'hFF);
    @(negedge clk);
    repeat (250) instr_q.push_back(rand_instr(1'b1));
    drain();

    // Last stretch runs with no idling on either side.
    write_reg(REG_IRQ_MASK, 64'd0);
    write_reg(REG_IRQ_ENABLE, 64'd0);
    write_reg(REG_WIRED_LIMIT, 64'd0);
    write_reg(REG_BOOT_VECTORS, 64'd0);
    @(negedge clk);
    calm = 1'b1;
    repeat (200) instr_q.push_back(rand_instr(1'b1));
    drain();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
